// ===== rtl/chip8_label_scan_and_decode_defines.svh =====
// ---------------------------------------------------------------------------
// chip8_label_scan_and_decode_defines.svh
// Assertion macros shared by the CHIP-8 label scan and decode block.
// ---------------------------------------------------------------------------
`ifndef CHIP8_LABEL_SCAN_AND_DECODE_DEFINES_SVH
`define CHIP8_LABEL_SCAN_AND_DECODE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define C8LSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define C8LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/c8lsd_pkg.sv =====
// ---------------------------------------------------------------------------
// c8lsd_pkg
// Types and constants of the CHIP-8 label scan and decode block.
// ---------------------------------------------------------------------------
package c8lsd_pkg;

    localparam int unsigned ADDR_W   = 12;
    localparam int unsigned OPCODE_W = 16;
    localparam int unsigned TBL_DEPTH = 4096;

    typedef enum logic {
        CMD_SCAN   = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        LBL_NONE  = 2'd0,
        LBL_START = 2'd1,
        LBL_SUB   = 2'd2,
        LBL_JUMP  = 2'd3
    } t_label;

    typedef enum logic [5:0] {
        MN_UNKNOWN  = 6'd0,
        MN_CLS      = 6'd1,
        MN_RET      = 6'd2,
        MN_SYS      = 6'd3,
        MN_JP       = 6'd4,
        MN_CALL     = 6'd5,
        MN_SE_BYTE  = 6'd6,
        MN_SNE_BYTE = 6'd7,
        MN_SE_REG   = 6'd8,
        MN_LD_BYTE  = 6'd9,
        MN_ADD_BYTE = 6'd10,
        MN_LD_REG   = 6'd11,
        MN_OR       = 6'd12,
        MN_AND      = 6'd13,
        MN_XOR      = 6'd14,
        MN_ADD_REG  = 6'd15,
        MN_SUB      = 6'd16,
        MN_SHR      = 6'd17,
        MN_SUBN     = 6'd18,
        MN_SHL      = 6'd19,
        MN_SNE_REG  = 6'd20,
        MN_LD_I     = 6'd21,
        MN_JP_V0    = 6'd22,
        MN_RND      = 6'd23,
        MN_DRW      = 6'd24,
        MN_SKP      = 6'd25,
        MN_SKNP     = 6'd26,
        MN_LD_VX_DT = 6'd27,
        MN_LD_VX_K  = 6'd28,
        MN_LD_DT_VX = 6'd29,
        MN_LD_ST_VX = 6'd30,
        MN_ADD_I_VX = 6'd31,
        MN_LD_F_VX  = 6'd32,
        MN_LD_B_VX  = 6'd33,
        MN_LD_MEM_VX = 6'd34,
        MN_LD_VX_MEM = 6'd35
    } t_mnem;

    // top nibble codes that matter to the scan pass
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;

endpackage

// ===== rtl/c8lsd_if.sv =====
// ---------------------------------------------------------------------------
// c8lsd_if
// Valid/ready channels: request in, decoded result out.
// ---------------------------------------------------------------------------
interface c8lsd_req_if import c8lsd_pkg::*; ();
    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [ADDR_W-1:0] word_address;
    logic [OPCODE_W-1:0] opcode;

    modport source (output valid, output command, output word_address, output opcode,
                    input ready);
    modport sink   (input valid, input command, input word_address, input opcode,
                    output ready);
endinterface

interface c8lsd_rsp_if import c8lsd_pkg::*; ();
    logic              valid;
    logic              ready;
    t_label            label_kind;
    t_mnem             mnemonic;
    logic [3:0]        reg_x;
    logic [3:0]        reg_y;
    logic [7:0]        imm_byte;
    logic [3:0]        low_nibble;
    logic [ADDR_W-1:0] target_address;
    logic [OPCODE_W-1:0] opcode_echo;

    modport source (output valid, output label_kind, output mnemonic, output reg_x,
                    output reg_y, output imm_byte, output low_nibble,
                    output target_address, output opcode_echo, input ready);
    modport sink   (input valid, input label_kind, input mnemonic, input reg_x,
                    input reg_y, input imm_byte, input low_nibble,
                    input target_address, input opcode_echo, output ready);
endinterface

// ===== rtl/c8lsd_ram.sv =====
// ---------------------------------------------------------------------------
// c8lsd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module c8lsd_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/chip8_label_scan_and_decode.sv =====
// ---------------------------------------------------------------------------
// chip8_label_scan_and_decode
// CHIP-8 two-pass disassembly core: label scan and instruction decode.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  i_req    | in  | valid / ready | command, word_address, opcode
//  o_rsp    | out | valid / ready | label_kind, mnemonic, reg_x, reg_y,
//           |     |               | imm_byte, low_nibble, target_address,
//           |     |               | opcode_echo
//
//  One request per cycle once the clearing pass is done and no decode is
//  stalled in stage 1. A decode result is registered in stage 1 (label
//  RAM read) and then in the output reg (decode logic).
//  A scan request gives no result; it writes the label RAM at acceptance
//  when its opcode is a JP or CALL. After reset a clearing pass walks the
//  4096-entry label RAM, one entry per cycle, and i_req.ready stays low
//  until it ends. A stalled o_rsp holds the output reg; a decode in stage
//  1 then holds and drops i_req.ready, while a scan there still retires.
// ---------------------------------------------------------------------------
`include "chip8_label_scan_and_decode_defines.svh"

module chip8_label_scan_and_decode
    import c8lsd_pkg::*;
#(
    parameter logic [11:0] START_ADDRESS = 12'h200
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c8lsd_req_if.sink   i_req,
    c8lsd_rsp_if.source o_rsp
);

    // ---------------- label RAM clearing pass ----------------
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == {ADDR_W{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- stage 1 (request register) ----------------
    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic [OPCODE_W-1:0] r_s1_op;

    // ---------------- output register ----------------
    logic                r_out_valid;
    t_label              r_out_label;
    t_mnem               r_out_mnem;
    logic [OPCODE_W-1:0] r_out_op;

    logic w_accept;
    logic w_out_free;
    logic w_s1_move;
    logic w_s1_to_out;

    // Output slot is free when empty or being drained this cycle.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    // A scan in stage 1 has already done its write and just retires.
    assign w_s1_move   = r_s1_valid && ((r_s1_cmd == CMD_SCAN) || w_out_free);
    assign w_s1_to_out = r_s1_valid && (r_s1_cmd == CMD_DECODE) && w_out_free;

    assign i_req.ready = !r_clr_busy && (!r_s1_valid || w_s1_move);
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd  <= i_req.command;
            r_s1_addr <= i_req.word_address;
            r_s1_op   <= i_req.opcode;
        end
    end

    // ---------------- label RAM ports ----------------
    // Scan writes and decode reads both happen at the acceptance edge, so
    // every decode sees all marks of earlier requests with no bypass.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [1:0]        w_wdata;
    logic              w_re;
    logic [1:0]        w_rdata;
    logic [3:0]        w_in_top;

    assign w_in_top = i_req.opcode[15:12];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_req.opcode[11:0];
        w_wdata = LBL_NONE;
        if (r_clr_busy) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = LBL_NONE;
        end else if (w_accept && (i_req.command == CMD_SCAN)) begin
            w_we    = (w_in_top == OP_JP) || (w_in_top == OP_CALL);
            w_wdata = (w_in_top == OP_JP) ? LBL_JUMP : LBL_SUB;
        end
    end

    assign w_re = w_accept && (i_req.command == CMD_DECODE);

    c8lsd_ram #(
        .WIDTH (2),
        .DEPTH (TBL_DEPTH)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (i_req.word_address),
        .o_rdata (w_rdata)
    );

    // ---------------- decode logic (stage 1 -> output) ----------------
    t_label     n_label;
    t_mnem      n_mnem;
    logic [3:0] w_top;
    logic [3:0] w_n;
    logic [7:0] w_kk;

    assign w_top = r_s1_op[15:12];
    assign w_n   = r_s1_op[3:0];
    assign w_kk  = r_s1_op[7:0];

    // The start address always lists as start, whatever marks land there.
    assign n_label = (r_s1_addr == START_ADDRESS) ? LBL_START : t_label'(w_rdata);

    always_comb begin
        n_mnem = MN_UNKNOWN;
        unique case (w_top)
            4'h0: begin
                if (r_s1_op[11:0] == 12'h0E0)      n_mnem = MN_CLS;
                else if (r_s1_op[11:0] == 12'h0EE) n_mnem = MN_RET;
                else                               n_mnem = MN_SYS;
            end
            4'h1: n_mnem = MN_JP;
            4'h2: n_mnem = MN_CALL;
            4'h3: n_mnem = MN_SE_BYTE;
            4'h4: n_mnem = MN_SNE_BYTE;
            4'h5: n_mnem = (w_n == 4'h0) ? MN_SE_REG : MN_UNKNOWN;
            4'h6: n_mnem = MN_LD_BYTE;
            4'h7: n_mnem = MN_ADD_BYTE;
            4'h8: begin
                unique case (w_n)
                    4'h0:    n_mnem = MN_LD_REG;
                    4'h1:    n_mnem = MN_OR;
                    4'h2:    n_mnem = MN_AND;
                    4'h3:    n_mnem = MN_XOR;
                    4'h4:    n_mnem = MN_ADD_REG;
                    4'h5:    n_mnem = MN_SUB;
                    4'h6:    n_mnem = MN_SHR;
                    4'h7:    n_mnem = MN_SUBN;
                    4'hE:    n_mnem = MN_SHL;
                    default: n_mnem = MN_UNKNOWN;
                endcase
            end
            4'h9: n_mnem = (w_n == 4'h0) ? MN_SNE_REG : MN_UNKNOWN;
            4'hA: n_mnem = MN_LD_I;
            4'hB: n_mnem = MN_JP_V0;
            4'hC: n_mnem = MN_RND;
            4'hD: n_mnem = MN_DRW;
            4'hE: begin
                if (w_kk == 8'h9E)      n_mnem = MN_SKP;
                else if (w_kk == 8'hA1) n_mnem = MN_SKNP;
                else                    n_mnem = MN_UNKNOWN;
            end
            4'hF: begin
                unique case (w_kk)
                    8'h07:   n_mnem = MN_LD_VX_DT;
                    8'h0A:   n_mnem = MN_LD_VX_K;
                    8'h15:   n_mnem = MN_LD_DT_VX;
                    8'h18:   n_mnem = MN_LD_ST_VX;
                    8'h1E:   n_mnem = MN_ADD_I_VX;
                    8'h29:   n_mnem = MN_LD_F_VX;
                    8'h33:   n_mnem = MN_LD_B_VX;
                    8'h55:   n_mnem = MN_LD_MEM_VX;
                    8'h65:   n_mnem = MN_LD_VX_MEM;
                    default: n_mnem = MN_UNKNOWN;
                endcase
            end
            default: n_mnem = MN_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_to_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_to_out) begin
            r_out_label <= n_label;
            r_out_mnem  <= n_mnem;
            r_out_op    <= r_s1_op;
        end
    end

    // Operand fields are raw slices of the opcode, used or not.
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.label_kind     = r_out_label;
    assign o_rsp.mnemonic       = r_out_mnem;
    assign o_rsp.reg_x          = r_out_op[11:8];
    assign o_rsp.reg_y          = r_out_op[7:4];
    assign o_rsp.imm_byte       = r_out_op[7:0];
    assign o_rsp.low_nibble     = r_out_op[3:0];
    assign o_rsp.target_address = r_out_op[11:0];
    assign o_rsp.opcode_echo    = r_out_op;

    // ---------------- assertions ----------------
    `C8LSD_ASSERT_NOW(a_no_accept_in_clear, r_clr_busy, !i_req.ready,
        "request accepted during label RAM clearing pass")
    `C8LSD_ASSERT_NEXT(a_decode_enters_s1, w_accept && (i_req.command == CMD_DECODE),
        r_s1_valid && (r_s1_cmd == CMD_DECODE), "accepted decode missing from stage 1")
    `C8LSD_ASSERT_NOW(a_clear_ends_at_top, $fell(r_clr_busy),
        $past(r_clr_addr) == {ADDR_W{1'b1}}, "clearing pass ended before last entry")
    // a scan in stage 1 retires even under stall, so only a decode must hold
    `C8LSD_ASSERT_NEXT(a_stalled_result_kept,
        r_out_valid && !o_rsp.ready && r_s1_valid && (r_s1_cmd == CMD_DECODE),
        r_out_valid && r_s1_valid, "result or stage 1 request lost under stall")

endmodule
